// ----- src/eph_pkg.sv -----
// ----------------------------------------------------------------------------
// eph_pkg
// Constants, types and the arctangent table for the Euler pose to
// homogeneous transform pipeline.
// ----------------------------------------------------------------------------
package eph_pkg;

    localparam int ANGLE_W   = 16;
    localparam int OFFSET_W  = 32;
    localparam int ROT_W     = 16;
    localparam int S_DATA_W  = 3 * ANGLE_W + 3 * OFFSET_W;
    localparam int M_DATA_W  = 9 * ROT_W + 3 * OFFSET_W;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    localparam int XY_W   = 33;   // Q.30 cosine / sine during rotation
    localparam int Z_W    = 35;   // Q.30 residual angle
    localparam int Q20_W  = 22;   // rounded Q.20 sine / cosine
    localparam int Q40_W  = 44;   // product of two Q.20 values
    localparam int Q60_W  = 67;   // element at Q.60 after the final add

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [Z_W-1:0]  PI_Q30      = Z_W'(64'sd3373259426);
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = Z_W'(64'sd1686629713);
    localparam logic signed [ROT_W-1:0] ROT_MAX    = ROT_W'(16384);

    typedef logic [ATAN_ENTRIES-1:0][31:0] t_atan_tbl;

    localparam t_atan_tbl ATAN_TBL = {
        32'd128,       32'd256,       32'd512,       32'd1024,
        32'd2048,      32'd4096,      32'd8192,      32'd16384,
        32'd32768,     32'd65536,     32'd131072,    32'd262144,
        32'd524288,    32'd1048576,   32'd2097149,   32'd4194283,
        32'd8388437,   32'd16775851,  32'd33543516,  32'd67021687,
        32'd133525159, 32'd263043837, 32'd497837829, 32'd843314857
    };

    // Q.60 to Q1.14: round half up, saturate to +-1.0
    function automatic logic signed [ROT_W-1:0] to_q14(input logic signed [Q60_W-1:0] v);
        logic signed [Q60_W-1:0] r;
        r = (v + (Q60_W'(1) <<< 45)) >>> 46;
        if (r > Q60_W'(ROT_MAX)) begin
            return ROT_MAX;
        end else if (r < -Q60_W'(ROT_MAX)) begin
            return -ROT_MAX;
        end
        return r[ROT_W-1:0];
    endfunction

endpackage

// ----- src/euler_pose_to_homogeneous_matrix.sv -----
// ----------------------------------------------------------------------------
// euler_pose_to_homogeneous_matrix
// Pose (roll, pitch, yaw, offset) to the top three rows of the 4x4
// homogeneous transform, R = Rz(yaw) * Ry(pitch) * Rx(roll).
// ----------------------------------------------------------------------------
//  channel | direction | fields (tdata, lowest bit first)
//  s_axis  | in        | roll, pitch, yaw (Q3.13), offset_x/y/z (Q16.16)
//  m_axis  | out       | rot_00..rot_22 (Q1.14), trans_x/y/z (Q16.16)
//
//  CORDIC_STAGES + 5 register stages (rotation capped at 24): one quadrant
//  fold, the rotation stages, one rounding stage, and three multiply / add
//  stages. One item enters per cycle unless a full pipeline is stalled by
//  m_axis_tready.
//  Every stage holds its own valid bit; a stage advances when it is empty
//  or the stage after it advances, so bubbles squeeze out under a stall.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module euler_pose_to_homogeneous_matrix #(
    parameter int CORDIC_STAGES = eph_pkg::CORDIC_STAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // roll, pitch, yaw, offset_x, offset_y, offset_z
    input  logic [eph_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21,
    // rot_22, trans_x, trans_y, trans_z
    output logic [eph_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import eph_pkg::*;

    localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    // stage numbers
    localparam int ST_RND = NS + 1;
    localparam int ST_M1  = NS + 2;
    localparam int ST_M2  = NS + 3;
    localparam int ST_M3  = NS + 4;
    localparam int DEPTH  = NS + 5;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] en;

    // advance a stage when it is empty or its successor advances
    always_comb begin
        en[DEPTH-1] = !r_vld[DEPTH-1] || m_axis_tready;
        for (int k = DEPTH - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < DEPTH; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // offsets ride along untouched
    logic [3*OFFSET_W-1:0] r_off [DEPTH];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_off[0] <= s_axis_tdata[S_DATA_W-1:3*ANGLE_W];
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (en[k]) begin
                r_off[k] <= r_off[k-1];
            end
        end
    end

    // CORDIC state per angle: 0 roll, 1 pitch, 2 yaw
    logic signed [XY_W-1:0] r_cx   [3][NS+1];
    logic signed [XY_W-1:0] r_cy   [3][NS+1];
    logic signed [Z_W-1:0]  r_cz   [3][NS+1];
    logic                   r_flip [3][NS+1];
    logic signed [Q20_W-1:0] r_cos [3];
    logic signed [Q20_W-1:0] r_sin [3];

    for (genvar a = 0; a < 3; a++) begin : g_ang
        logic signed [Z_W-1:0] z_in;
        assign z_in = Z_W'($signed(s_axis_tdata[a*ANGLE_W +: ANGLE_W])) <<< 17;

        // fold into +-pi/2, remember to negate the result
        always_ff @(posedge i_clk) begin
            if (en[0]) begin
                r_cx[a][0] <= CORDIC_GAIN;
                r_cy[a][0] <= '0;
                if (z_in > HALF_PI_Q30) begin
                    r_cz[a][0]   <= z_in - PI_Q30;
                    r_flip[a][0] <= 1'b1;
                end else if (z_in < -HALF_PI_Q30) begin
                    r_cz[a][0]   <= z_in + PI_Q30;
                    r_flip[a][0] <= 1'b1;
                end else begin
                    r_cz[a][0]   <= z_in;
                    r_flip[a][0] <= 1'b0;
                end
            end
        end

        for (genvar s = 0; s < NS; s++) begin : g_rot
            localparam logic signed [Z_W-1:0] ATAN_S = Z_W'(ATAN_TBL[s]);
            always_ff @(posedge i_clk) begin
                if (en[s+1]) begin
                    r_flip[a][s+1] <= r_flip[a][s];
                    if (r_cz[a][s] >= 0) begin
                        r_cx[a][s+1] <= r_cx[a][s] - (r_cy[a][s] >>> s);
                        r_cy[a][s+1] <= r_cy[a][s] + (r_cx[a][s] >>> s);
                        r_cz[a][s+1] <= r_cz[a][s] - ATAN_S;
                    end else begin
                        r_cx[a][s+1] <= r_cx[a][s] + (r_cy[a][s] >>> s);
                        r_cy[a][s+1] <= r_cy[a][s] - (r_cx[a][s] >>> s);
                        r_cz[a][s+1] <= r_cz[a][s] + ATAN_S;
                    end
                end
            end
        end

        // undo the fold, round Q.30 to Q.20
        logic signed [XY_W-1:0] fx, fy, rx, ry;
        assign fx = r_flip[a][NS] ? -r_cx[a][NS] : r_cx[a][NS];
        assign fy = r_flip[a][NS] ? -r_cy[a][NS] : r_cy[a][NS];
        assign rx = (fx + XY_W'(512)) >>> 10;
        assign ry = (fy + XY_W'(512)) >>> 10;

        always_ff @(posedge i_clk) begin
            if (en[ST_RND]) begin
                r_cos[a] <= rx[Q20_W-1:0];
                r_sin[a] <= ry[Q20_W-1:0];
            end
        end
    end

    logic signed [Q20_W-1:0] cr, sr, cp, sp, cy, sy;
    assign cr = r_cos[0];
    assign sr = r_sin[0];
    assign cp = r_cos[1];
    assign sp = r_sin[1];
    assign cy = r_cos[2];
    assign sy = r_sin[2];

    // first multiply level: pairs at Q.40
    logic signed [Q40_W-1:0] r_cysp, r_sysp, r_sycr, r_sysr, r_cycr, r_cysr;
    logic signed [Q40_W-1:0] r_cycp, r_sycp, r_cpsr, r_cpcr, r_sp1;
    logic signed [Q20_W-1:0] r_sr1, r_cr1;

    always_ff @(posedge i_clk) begin
        if (en[ST_M1]) begin
            r_cysp <= Q40_W'(cy) * Q40_W'(sp);
            r_sysp <= Q40_W'(sy) * Q40_W'(sp);
            r_sycr <= Q40_W'(sy) * Q40_W'(cr);
            r_sysr <= Q40_W'(sy) * Q40_W'(sr);
            r_cycr <= Q40_W'(cy) * Q40_W'(cr);
            r_cysr <= Q40_W'(cy) * Q40_W'(sr);
            r_cycp <= Q40_W'(cy) * Q40_W'(cp);
            r_sycp <= Q40_W'(sy) * Q40_W'(cp);
            r_cpsr <= Q40_W'(cp) * Q40_W'(sr);
            r_cpcr <= Q40_W'(cp) * Q40_W'(cr);
            r_sp1  <= Q40_W'(sp) <<< 20;
            r_sr1  <= sr;
            r_cr1  <= cr;
        end
    end

    // second level: triple products and scaled pairs at Q.60
    logic signed [Q60_W-1:0] r_t01, r_t02, r_t11, r_t12;
    logic signed [Q60_W-1:0] r_u01, r_u02, r_u11, r_u12;
    logic signed [Q60_W-1:0] r_e00, r_e10, r_e20, r_e21, r_e22;

    always_ff @(posedge i_clk) begin
        if (en[ST_M2]) begin
            r_t01 <= Q60_W'(r_cysp) * Q60_W'(r_sr1);
            r_t02 <= Q60_W'(r_cysp) * Q60_W'(r_cr1);
            r_t11 <= Q60_W'(r_sysp) * Q60_W'(r_sr1);
            r_t12 <= Q60_W'(r_sysp) * Q60_W'(r_cr1);
            r_u01 <= Q60_W'(r_sycr) <<< 20;
            r_u02 <= Q60_W'(r_sysr) <<< 20;
            r_u11 <= Q60_W'(r_cycr) <<< 20;
            r_u12 <= Q60_W'(r_cysr) <<< 20;
            r_e00 <= Q60_W'(r_cycp) <<< 20;
            r_e10 <= Q60_W'(r_sycp) <<< 20;
            r_e20 <= -(Q60_W'(r_sp1) <<< 20);
            r_e21 <= Q60_W'(r_cpsr) <<< 20;
            r_e22 <= Q60_W'(r_cpcr) <<< 20;
        end
    end

    // combine, round and saturate into the output register
    logic [9*ROT_W-1:0] r_rot;

    always_ff @(posedge i_clk) begin
        if (en[ST_M3]) begin
            r_rot <= {to_q14(r_e22), to_q14(r_e21), to_q14(r_e20),
                      to_q14(r_t12 - r_u12), to_q14(r_t11 + r_u11), to_q14(r_e10),
                      to_q14(r_t02 + r_u02), to_q14(r_t01 - r_u01), to_q14(r_e00)};
        end
    end

    assign m_axis_tvalid = r_vld[DEPTH-1];
    assign m_axis_tdata  = {r_off[DEPTH-1], r_rot};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline full and stalled");

    a_rot20_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[7*ROT_W-1:6*ROT_W]) <= ROT_MAX &&
                           $signed(m_axis_tdata[7*ROT_W-1:6*ROT_W]) >= -ROT_MAX))
        else $error("rot_20 out of range");

endmodule
